>>> hdl/fsp_pkg.sv
`timescale 1ns / 1ps

package fsp_pkg;

  // One input item: a start marker or one format byte
  typedef struct packed {
    logic               kind;
    logic [7:0]         char_in;
    logic signed [31:0] star_arg;
  } in_item_t;

  // One parsed conversion specifier
  typedef struct packed {
    logic               flag_alt;
    logic               flag_zero_pad;
    logic               flag_plus;
    logic               flag_left;
    logic               flag_space;
    logic [30:0]        field_width;
    logic signed [31:0] precision_out;
    logic [2:0]         length_code;
    logic [7:0]         conversion;
    logic               conversion_valid;
  } out_item_t;

  localparam logic KindStart = 1'b0;

  // Parse phases, in the order a specifier moves through them
  localparam logic [2:0] PhFlags = 3'd0;
  localparam logic [2:0] PhWstar = 3'd1;
  localparam logic [2:0] PhWdig  = 3'd2;
  localparam logic [2:0] PhDot   = 3'd3;
  localparam logic [2:0] PhPdig  = 3'd4;
  localparam logic [2:0] PhPstar = 3'd5;
  localparam logic [2:0] PhLen1  = 3'd6;
  localparam logic [2:0] PhLenN  = 3'd7;

  localparam logic [2:0] LenNone = 3'd0;
  localparam logic [2:0] LenHH   = 3'd1;
  localparam logic [2:0] LenH    = 3'd2;
  localparam logic [2:0] LenL    = 3'd3;
  localparam logic [2:0] LenLL   = 3'd4;
  localparam logic [2:0] LenBigL = 3'd5;

  // Flag bit positions
  localparam int unsigned FlAlt   = 0;
  localparam int unsigned FlZero  = 1;
  localparam int unsigned FlPlus  = 2;
  localparam int unsigned FlLeft  = 3;
  localparam int unsigned FlSpace = 4;

  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChOne   = 8'h31;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChH     = 8'h68;
  localparam logic [7:0] ChL     = 8'h6C;
  localparam logic [7:0] ChBigL  = 8'h4C;

  localparam logic [30:0]        MaxVal  = 31'h7FFF_FFFF;
  localparam logic signed [31:0] PrecNone = -32'sd1;

  function automatic logic is_conv(input logic [7:0] c);
    logic r;
    case (c)
      8'h25, 8'h64, 8'h69, 8'h75, 8'h6F, 8'h78, 8'h58, 8'h66, 8'h46, 8'h65,
      8'h45, 8'h67, 8'h47, 8'h61, 8'h41, 8'h63, 8'h73, 8'h70, 8'h6E, 8'h62:
        r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // acc * 10 + d, saturating at MaxVal; the multiply is two shifts and an add
  function automatic logic [30:0] acc_digit(input logic [30:0] acc, input logic [3:0] d);
    logic [34:0] v;
    v = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {31'b0, d};
    return (v > {4'b0, MaxVal}) ? MaxVal : v[30:0];
  endfunction

endpackage

>>> hdl/fsp_core.sv
`timescale 1ns / 1ps

module fsp_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_en_i,
  input  fsp_pkg::in_item_t item_i,
  output logic              emit_o,
  output fsp_pkg::out_item_t record_o
);
  import fsp_pkg::*;

  logic [2:0]         phase_q, phase_d;
  logic [4:0]         flags_q, flags_d;
  logic [30:0]        width_q, width_d;
  logic               wneg_q, wneg_d;
  logic signed [31:0] prec_q, prec_d;
  logic [2:0]         len_q, len_d;

  logic [7:0]  c;
  logic [3:0]  dval;
  logic        digit, nz, is_len;
  logic [31:0] star_mag;

  assign c        = item_i.char_in;
  assign dval     = 4'(c - ChZero);
  assign digit    = (c >= ChZero) && (c <= ChNine);
  assign nz       = (c >= ChOne) && (c <= ChNine);
  assign is_len   = (c == ChH) || (c == ChL) || (c == ChBigL);
  assign star_mag = 32'(-item_i.star_arg);

  always_comb begin
    record_o.flag_alt         = flags_q[FlAlt];
    record_o.flag_zero_pad    = flags_q[FlZero];
    record_o.flag_plus        = flags_q[FlPlus];
    record_o.flag_left        = flags_q[FlLeft] | wneg_q;
    record_o.flag_space       = flags_q[FlSpace];
    record_o.field_width      = width_q;
    record_o.precision_out    = prec_q;
    record_o.length_code      = len_q;
    record_o.conversion       = c;
    record_o.conversion_valid = is_conv(c);
  end

  always_comb begin
    phase_d = phase_q;
    flags_d = flags_q;
    width_d = width_q;
    wneg_d  = wneg_q;
    prec_d  = prec_q;
    len_d   = len_q;
    emit_o  = 1'b0;
    if (item_i.kind == KindStart) begin
      phase_d = PhFlags;
      flags_d = '0;
      width_d = '0;
      wneg_d  = 1'b0;
      prec_d  = PrecNone;
      len_d   = LenNone;
    end else if (phase_q == PhFlags && c == ChHash) begin
      flags_d[FlAlt] = 1'b1;
    end else if (phase_q == PhFlags && c == ChZero) begin
      flags_d[FlZero] = 1'b1;
    end else if (phase_q == PhFlags && c == ChPlus) begin
      flags_d[FlPlus] = 1'b1;
    end else if (phase_q == PhFlags && c == ChMinus) begin
      flags_d[FlLeft] = 1'b1;
    end else if (phase_q == PhFlags && c == ChSpace) begin
      flags_d[FlSpace] = 1'b1;
    end else if (phase_q == PhFlags && c == ChStar) begin
      if (item_i.star_arg[31]) begin
        wneg_d  = 1'b1;
        // only the most negative value has a magnitude past the limit
        width_d = star_mag[31] ? MaxVal : star_mag[30:0];
      end else begin
        wneg_d  = 1'b0;
        width_d = item_i.star_arg[30:0];
      end
      phase_d = PhWstar;
    end else if (phase_q <= PhWstar && nz) begin
      wneg_d  = 1'b0;
      width_d = {27'b0, dval};
      phase_d = PhWdig;
    end else if (phase_q == PhWdig && digit) begin
      width_d = acc_digit(width_q, dval);
    end else if (phase_q <= PhWdig && c == ChDot) begin
      prec_d  = '0;
      phase_d = PhDot;
    end else if (phase_q == PhDot && c == ChStar) begin
      prec_d  = item_i.star_arg;
      phase_d = PhPstar;
    end else if ((phase_q == PhDot || phase_q == PhPdig) && digit) begin
      // precision is never negative here
      prec_d  = {1'b0, acc_digit(prec_q[30:0], dval)};
      phase_d = PhPdig;
    end else if (phase_q == PhPstar && digit) begin
      // digits after a star precision are skipped
    end else if (is_len) begin
      if (phase_q <= PhPstar) begin
        len_d   = (c == ChH) ? LenH : ((c == ChL) ? LenL : LenBigL);
        phase_d = PhLen1;
      end else if (phase_q == PhLen1) begin
        if (len_q == LenH && c == ChH) begin
          len_d = LenHH;
        end else if (len_q == LenL && c == ChL) begin
          len_d = LenLL;
        end
        phase_d = PhLenN;
      end
    end else begin
      emit_o  = 1'b1;
      phase_d = PhFlags;
      flags_d = '0;
      width_d = '0;
      wneg_d  = 1'b0;
      prec_d  = PrecNone;
      len_d   = LenNone;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhFlags;
      flags_q <= '0;
      width_q <= '0;
      wneg_q  <= 1'b0;
      prec_q  <= PrecNone;
      len_q   <= LenNone;
    end else if (step_en_i) begin
      phase_q <= phase_d;
      flags_q <= flags_d;
      width_q <= width_d;
      wneg_q  <= wneg_d;
      prec_q  <= prec_d;
      len_q   <= len_d;
    end
  end

endmodule

>>> hdl/fsp_out_reg.sv
`timescale 1ns / 1ps

module fsp_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  fsp_pkg::out_item_t data_i,
  output logic               free_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output fsp_pkg::out_item_t out_item_o
);
  import fsp_pkg::*;

  logic      valid_q;
  out_item_t data_q;

  // room for a new record when empty or when the held one transfers now
  assign free_o      = !valid_q || !out_stall_i;
  assign out_valid_o = valid_q;
  assign out_item_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

endmodule

>>> hdl/format_specifier_parser.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_stall_o   in_item_i  (kind, char_in, star_arg)
// out       output     out_valid_o / out_stall_i out_item_o (flags, width, precision, ...)
//
// One item per cycle sustained, except while a stalled output holds the input stage (below);
// an input transfer reaches the record via the input register, then the parse step into the output register.
// The parse step is a phase update plus one saturating multiply-by-ten accumulate.
// Reset puts the parser in the flags phase with defaults, precision -1.
// A stalled output only holds the input stage back when the waiting item ends a specifier.
module format_specifier_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  fsp_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output fsp_pkg::out_item_t out_item_o
);
  import fsp_pkg::*;

  logic      in_valid_q;
  in_item_t  in_item_q;
  logic      emit;
  logic      out_free;
  logic      step;
  out_item_t record;

  assign step       = in_valid_q && (!emit || out_free);
  assign in_stall_o = in_valid_q && !step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_item_q <= in_item_i;
    end
  end

  fsp_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (step),
    .item_i    (in_item_q),
    .emit_o    (emit),
    .record_o  (record)
  );

  fsp_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step && emit),
    .data_i      (record),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
